FILE: sv/pts_pkg.sv
// Package for the priority task scheduler: widths, event kinds, status codes,
// controller states and the command/status structs. No dependencies.
package pts_pkg;

    localparam int NUM_PRIOS_DEF = 32;
    localparam int NUM_TASKS_DEF = 32;
    localparam int ID_W          = 5;
    localparam int SLICE_W       = 16;
    localparam int DEPTH_W       = 8;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 8'd255;
    localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd10;

    typedef enum logic [2:0] {
        K_MAKE_READY = 3'd0,
        K_REMOVE     = 3'd1,
        K_SWITCH     = 3'd2,
        K_TICK       = 3'd3,
        K_BLOCK      = 3'd4,
        K_SUSPEND    = 3'd5,
        K_RESUME     = 3'd6,
        K_UNUSED     = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOREADY = 2'd1,
        ST_INVALID = 2'd2,
        ST_RSVD    = 2'd3
    } status_t;

    // Controller states; every event walks a subset of these.
    typedef enum logic [3:0] {
        S_IDLE,     // wait for a word
        S_DECODE,   // checks, per-task reads
        S_ENQ,      // enqueue a task at its tail
        S_ENQ2,     // enqueue: link fixups
        S_UNL,      // unlink: read links of the task
        S_UNL2,     // unlink: apply
        S_SWPICK,   // switch: pick head of best priority
        S_SWDONE,   // switch: finalize current task
        S_OUT       // result word waits for the receiver
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_DECODE,
        OP_ENQ_A,
        OP_ENQ_B,
        OP_UNL_A,
        OP_UNL_B,
        OP_PICK,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t  op;
        logic load;       // capture input word
        logic enq_cur;    // enqueue target is the current task
        logic unl_pick;   // unlink target is the picked head
    } cmd_t;

    typedef struct packed {
        logic    done;        // event finished at decode
        logic    need_enq;    // valid make_ready
        logic    need_unl;    // valid remove
        logic    is_switch;   // switch needs a pick
        logic    enq_cur;     // switch must requeue current first
        logic    pick_self;   // picked task equals current
    } sts_t;

endpackage

FILE: sv/pts_datapath.sv
// Datapath of the scheduler: per-priority queue tables, per-task link tables,
// ready bitmap and scheduler registers. Depends on pts_pkg; driven by pts_ctrl.
module pts_datapath #(
    parameter int NUM_PRIOS = pts_pkg::NUM_PRIOS_DEF,
    parameter int NUM_TASKS = pts_pkg::NUM_TASKS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic                         cfg_addr,
    input  logic [pts_pkg::SLICE_W-1:0]  cfg_wdata,
    input  logic [2:0]                   in_kind,
    input  logic [pts_pkg::ID_W-1:0]     in_task_id,
    input  logic [pts_pkg::ID_W-1:0]     in_task_prio,
    input  pts_pkg::cmd_t                cmd,
    output pts_pkg::sts_t                sts,
    output logic [pts_pkg::ID_W-1:0]     o_task,
    output logic                         o_valid,
    output logic                         o_yield,
    output logic                         o_switched,
    output logic                         o_yreq,
    output logic [1:0]                   o_status
);
    localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int PW = (NUM_PRIOS > 1) ? $clog2(NUM_PRIOS) : 1;
    localparam int ID_W = pts_pkg::ID_W;
    localparam int SLICE_W = pts_pkg::SLICE_W;

    // tables (undefined until written)
    logic [TW-1:0] head_mem [NUM_PRIOS];
    logic [TW-1:0] tail_mem [NUM_PRIOS];
    logic [TW-1:0] next_mem [NUM_TASKS];
    logic [TW-1:0] prev_mem [NUM_TASKS];
    logic [PW-1:0] prio_mem [NUM_TASKS];

    logic [NUM_PRIOS-1:0] bitmap_reg;
    logic [NUM_TASKS-1:0] queued_reg;
    logic [TW-1:0]        cur_reg;
    logic                 cur_valid_reg, cur_run_reg, yield_reg;
    logic [SLICE_W-1:0]   slice_reg, slice_ticks_reg;
    logic                 slicing_reg;
    logic [pts_pkg::DEPTH_W-1:0] depth_reg;

    // captured word
    pts_pkg::kind_t kind_reg;
    logic [ID_W-1:0] tid_reg, tpr_reg;
    logic            switched_reg, yreq_reg;
    pts_pkg::status_t status_reg;

    // working registers
    logic [TW-1:0] tgt_reg;       // task being enqueued or unlinked
    logic [PW-1:0] tp_reg;        // its priority
    logic [PW-1:0] cur_prio_reg;  // priority of current task
    logic [TW-1:0] hd_reg, tl_reg, lnx_reg, lpv_reg;
    logic          ne_reg;        // target priority queue nonempty
    logic [TW-1:0] pick_reg;

    // lowest set bit of the bitmap
    logic [PW-1:0] best_c;
    always_comb begin
        best_c = '0;
        for (int i = NUM_PRIOS - 1; i >= 0; i--) begin
            if (bitmap_reg[i]) best_c = PW'(i);
        end
    end

    logic tid_ok, tpr_ok;
    assign tid_ok = ({{(32-ID_W){1'b0}}, tid_reg} < 32'(NUM_TASKS));
    assign tpr_ok = ({{(32-ID_W){1'b0}}, tpr_reg} < 32'(NUM_PRIOS));
    logic [TW-1:0] tid_i;
    assign tid_i = TW'(tid_reg);

    // decode status
    always_comb begin
        sts.done = 1'b0;
        sts.need_enq = 1'b0;
        sts.need_unl = 1'b0;
        sts.is_switch = 1'b0;
        sts.enq_cur = cur_valid_reg && cur_run_reg && (cur_reg != pick_reg);
        sts.pick_self = cur_valid_reg && (cur_reg == pick_reg);
        case (kind_reg)
            pts_pkg::K_MAKE_READY: begin
                if (tid_ok && tpr_ok && !queued_reg[tid_i] &&
                    !(cur_valid_reg && cur_run_reg && cur_reg == tid_i))
                    sts.need_enq = 1'b1;
                else sts.done = 1'b1;
            end
            pts_pkg::K_REMOVE: begin
                if (tid_ok && queued_reg[tid_i]) sts.need_unl = 1'b1;
                else sts.done = 1'b1;
            end
            pts_pkg::K_SWITCH: begin
                if (depth_reg == '0 && bitmap_reg != '0) sts.is_switch = 1'b1;
                else sts.done = 1'b1;
            end
            default: sts.done = 1'b1;
        endcase
    end

    logic [TW-1:0] enq_t;
    always_comb enq_t = cmd.enq_cur ? cur_reg : tid_i;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bitmap_reg      <= '0;
            queued_reg      <= '0;
            cur_reg         <= '0;
            cur_valid_reg   <= 1'b0;
            cur_run_reg     <= 1'b0;
            yield_reg       <= 1'b0;
            slice_reg       <= '0;
            depth_reg       <= '0;
            slice_ticks_reg <= pts_pkg::SLICE_RESET;
            slicing_reg     <= 1'b1;
            kind_reg        <= pts_pkg::K_UNUSED;
            switched_reg    <= 1'b0;
            yreq_reg        <= 1'b0;
            status_reg      <= pts_pkg::ST_OK;
        end else begin
            if (cfg_we) begin
                if (!cfg_addr) slice_ticks_reg <= cfg_wdata;
                else slicing_reg <= cfg_wdata[0];
            end
            if (cmd.load) begin
                kind_reg     <= pts_pkg::kind_t'(in_kind);
                tid_reg      <= in_task_id;
                tpr_reg      <= in_task_prio;
                switched_reg <= 1'b0;
                yreq_reg     <= 1'b0;
                status_reg   <= pts_pkg::ST_OK;
                cur_prio_reg <= prio_mem[cur_reg];
            end
            case (cmd.op)
                pts_pkg::OP_DECODE: begin
                    pick_reg <= head_mem[best_c];
                    case (kind_reg)
                        pts_pkg::K_MAKE_READY: begin
                            if (!sts.need_enq) status_reg <= pts_pkg::ST_INVALID;
                            else begin
                                prio_mem[tid_i] <= tpr_reg[PW-1:0];
                                // a re-readied current task takes the new priority
                                if (cur_valid_reg && cur_reg != tid_i &&
                                    tpr_reg[PW-1:0] < cur_prio_reg)
                                    yield_reg <= 1'b1;
                            end
                        end
                        pts_pkg::K_REMOVE:
                            if (!sts.need_unl) status_reg <= pts_pkg::ST_INVALID;
                        pts_pkg::K_SWITCH: begin
                            if (depth_reg != '0) yield_reg <= 1'b1;
                            else if (bitmap_reg == '0)
                                status_reg <= pts_pkg::ST_NOREADY;
                        end
                        pts_pkg::K_TICK: begin
                            if (cur_valid_reg && depth_reg == '0 && slicing_reg) begin
                                if (slice_reg <= SLICE_W'(1)) begin
                                    if (bitmap_reg[cur_prio_reg]) begin
                                        slice_reg <= '0;
                                        yield_reg <= 1'b1;
                                    end else slice_reg <= slice_ticks_reg;
                                end else slice_reg <= slice_reg - SLICE_W'(1);
                            end
                        end
                        pts_pkg::K_BLOCK: begin
                            if (!cur_valid_reg || !cur_run_reg)
                                status_reg <= pts_pkg::ST_INVALID;
                            else cur_run_reg <= 1'b0;
                        end
                        pts_pkg::K_SUSPEND: begin
                            if (depth_reg == pts_pkg::DEPTH_MAX)
                                status_reg <= pts_pkg::ST_INVALID;
                            else depth_reg <= depth_reg + 8'd1;
                        end
                        pts_pkg::K_RESUME: begin
                            if (depth_reg == '0) status_reg <= pts_pkg::ST_INVALID;
                            else begin
                                depth_reg <= depth_reg - 8'd1;
                                yreq_reg <= (depth_reg == 8'd1) && yield_reg;
                            end
                        end
                        default: status_reg <= pts_pkg::ST_INVALID;
                    endcase
                end
                pts_pkg::OP_ENQ_A: begin
                    tgt_reg <= enq_t;
                    tp_reg  <= cmd.enq_cur ? cur_prio_reg : tpr_reg[PW-1:0];
                    ne_reg  <= bitmap_reg[cmd.enq_cur ? cur_prio_reg : tpr_reg[PW-1:0]];
                    tl_reg  <= tail_mem[cmd.enq_cur ? cur_prio_reg : tpr_reg[PW-1:0]];
                end
                pts_pkg::OP_ENQ_B: begin
                    if (!ne_reg) begin
                        head_mem[tp_reg] <= tgt_reg;
                        prev_mem[tgt_reg] <= tgt_reg;
                        bitmap_reg[tp_reg] <= 1'b1;
                    end else begin
                        next_mem[tl_reg] <= tgt_reg;
                        prev_mem[tgt_reg] <= tl_reg;
                    end
                    tail_mem[tp_reg] <= tgt_reg;
                    next_mem[tgt_reg] <= tgt_reg;
                    queued_reg[tgt_reg] <= 1'b1;
                end
                pts_pkg::OP_UNL_A: begin
                    tgt_reg <= cmd.unl_pick ? pick_reg : tid_i;
                    tp_reg  <= prio_mem[cmd.unl_pick ? pick_reg : tid_i];
                    lnx_reg <= next_mem[cmd.unl_pick ? pick_reg : tid_i];
                    lpv_reg <= prev_mem[cmd.unl_pick ? pick_reg : tid_i];
                    hd_reg  <= head_mem[prio_mem[cmd.unl_pick ? pick_reg : tid_i]];
                    tl_reg  <= tail_mem[prio_mem[cmd.unl_pick ? pick_reg : tid_i]];
                end
                pts_pkg::OP_UNL_B: begin
                    if (hd_reg == tgt_reg && tl_reg == tgt_reg)
                        bitmap_reg[tp_reg] <= 1'b0;
                    else if (hd_reg == tgt_reg) head_mem[tp_reg] <= lnx_reg;
                    else if (tl_reg == tgt_reg) tail_mem[tp_reg] <= lpv_reg;
                    else begin
                        next_mem[lpv_reg] <= lnx_reg;
                        prev_mem[lnx_reg] <= lpv_reg;
                    end
                    queued_reg[tgt_reg] <= 1'b0;
                end
                pts_pkg::OP_PICK: begin
                    // pick was latched at decode, so a later requeue of the current task does not change it
                    switched_reg <= !sts.pick_self;
                end
                pts_pkg::OP_FINISH: begin
                    cur_reg       <= pick_reg;
                    cur_valid_reg <= 1'b1;
                    cur_run_reg   <= 1'b1;
                    slice_reg     <= slice_ticks_reg;
                    yield_reg     <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign o_task     = ID_W'(cur_reg);
    assign o_valid    = cur_valid_reg;
    assign o_yield    = yield_reg;
    assign o_switched = switched_reg;
    assign o_yreq     = yreq_reg;
    assign o_status   = status_reg;
endmodule

FILE: sv/pts_ctrl.sv
// Controller FSM of the scheduler: sequences table reads and writes per event
// and runs the stream handshake. Depends on pts_pkg.
module pts_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    input  pts_pkg::sts_t sts,
    output pts_pkg::cmd_t cmd
);
    pts_pkg::state_t state_reg, state_next;
    logic enq_cur_reg, enq_cur_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pts_pkg::S_IDLE;
            enq_cur_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            enq_cur_reg <= enq_cur_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        enq_cur_next  = enq_cur_reg;
        cmd           = '{op: pts_pkg::OP_NONE, load: 1'b0, enq_cur: 1'b0,
                          unl_pick: 1'b0};
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        case (state_reg)
            pts_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    cmd.load = 1'b1;
                    state_next = pts_pkg::S_DECODE;
                end
            end
            pts_pkg::S_DECODE: begin
                cmd.op = pts_pkg::OP_DECODE;
                enq_cur_next = 1'b0;
                if (sts.need_enq) state_next = pts_pkg::S_ENQ;
                else if (sts.need_unl) state_next = pts_pkg::S_UNL;
                else if (sts.is_switch) state_next = pts_pkg::S_SWPICK;
                else state_next = pts_pkg::S_OUT;
            end
            pts_pkg::S_SWPICK: begin
                cmd.op = pts_pkg::OP_PICK;
                enq_cur_next = sts.enq_cur;
                state_next = sts.enq_cur ? pts_pkg::S_ENQ : pts_pkg::S_UNL;
            end
            pts_pkg::S_ENQ: begin
                cmd.op = pts_pkg::OP_ENQ_A;
                cmd.enq_cur = enq_cur_reg;
                state_next = pts_pkg::S_ENQ2;
            end
            pts_pkg::S_ENQ2: begin
                cmd.op = pts_pkg::OP_ENQ_B;
                state_next = enq_cur_reg ? pts_pkg::S_UNL : pts_pkg::S_OUT;
            end
            pts_pkg::S_UNL: begin
                cmd.op = pts_pkg::OP_UNL_A;
                cmd.unl_pick = sts.is_switch;
                state_next = pts_pkg::S_UNL2;
            end
            pts_pkg::S_UNL2: begin
                cmd.op = pts_pkg::OP_UNL_B;
                state_next = sts.is_switch ? pts_pkg::S_SWDONE : pts_pkg::S_OUT;
            end
            pts_pkg::S_SWDONE: begin
                cmd.op = pts_pkg::OP_FINISH;
                state_next = pts_pkg::S_OUT;
            end
            pts_pkg::S_OUT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) state_next = pts_pkg::S_IDLE;
            end
            default: state_next = pts_pkg::S_IDLE;
        endcase
    end
endmodule

FILE: sv/priority_task_scheduler_top.sv
// Top level of the priority task scheduler: stream ports, config port,
// controller and datapath. Depends on pts_pkg, pts_ctrl, pts_datapath.
//
// Usage: one event word in on s_axis, exactly one result word out on m_axis.
// s_axis_tuser: kind[2:0]. s_axis_tdata: task_id[4:0], task_prio[9:5], zero filled.
// m_axis_tdata: running_task[4:0], running_valid[5], yield_flag[6],
//   switched[7], yield_request[8], status[10:9], zero filled.
// One event at a time: checks, suspend, resume, tick, block end at decode;
// make_ready or remove add an enqueue or unlink, a switch a pick, unlink
// and finish, with a requeue of a still-running outgoing task first; the steps follow
// sequential reads and writes of the link and queue tables, one port each.
// The result sits in a register until m_axis_tready; s_axis_tready stays
// low meanwhile, so a stalled receiver stalls the sender.
// Reset (aresetn low, synchronous) empties all queues, clears the current
// task, suspend depth and yield flag, and sets slice_ticks 10, slicing on.
// Config: cfg_we writes cfg_wdata to register cfg_addr (0 slice_ticks,
// 1 slicing_on); user writes only while no event is in flight (not enforced).
module priority_task_scheduler_top #(
    parameter int NUM_PRIOS = pts_pkg::NUM_PRIOS_DEF,
    parameter int NUM_TASKS = pts_pkg::NUM_TASKS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [2:0]  s_axis_tuser,  // kind
    input  logic [15:0] s_axis_tdata,  // task_id, task_prio
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // running_task, running_valid, yield_flag,
                                       // switched, yield_request, status
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata
);
    pts_pkg::cmd_t cmd;
    pts_pkg::sts_t sts;
    logic [4:0] o_task;
    logic o_valid, o_yield, o_switched, o_yreq;
    logic [1:0] o_status;

    pts_ctrl u_ctrl (
        .aclk, .aresetn, .s_axis_tvalid, .s_axis_tready,
        .m_axis_tvalid, .m_axis_tready, .sts, .cmd
    );

    pts_datapath #(.NUM_PRIOS(NUM_PRIOS), .NUM_TASKS(NUM_TASKS)) u_dp (
        .aclk, .aresetn, .cfg_we, .cfg_addr, .cfg_wdata,
        .in_kind(s_axis_tuser), .in_task_id(s_axis_tdata[4:0]),
        .in_task_prio(s_axis_tdata[9:5]), .cmd, .sts,
        .o_task, .o_valid, .o_yield, .o_switched, .o_yreq, .o_status
    );

    assign m_axis_tdata = {5'd0, o_status, o_yreq, o_switched, o_yield, o_valid, o_task};
endmodule
